/* sv/bms_pkg.sv */
// ----------------------------------------------------------------------------
// bms_pkg
// Types and constants shared by the button mode sequencer and sensor override.
// ----------------------------------------------------------------------------
package bms_pkg;

    localparam int NUM_SCENARIOS = 5;
    localparam int SCN_W         = 3;
    localparam int HOLD_W        = 16;
    localparam int FAULT_W       = 3;
    localparam int LEAF_W        = 16;
    localparam int MOIST_W       = 16;
    localparam int ILLUM_W       = 31;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int IN_DATA_W     = 72;
    localparam int OUT_DATA_W    = 72;

    // scenario codes
    localparam logic [SCN_W-1:0] SCN_OFF    = 3'd0;
    localparam logic [SCN_W-1:0] SCN_CLAMP  = 3'd1;
    localparam logic [SCN_W-1:0] SCN_BOOST  = 3'd2;
    localparam logic [SCN_W-1:0] SCN_DRY    = 3'd3;
    localparam logic [SCN_W-1:0] SCN_EMPTY  = 3'd4;
    localparam logic [SCN_W-1:0] SCN_FAULT  = 3'd5;
    localparam logic [SCN_W-1:0] SCN_LAST   = SCN_W'(NUM_SCENARIOS);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_CODE     = 2'd1;

    localparam logic [HOLD_W-1:0]  HOLD_THRESHOLD_RST = 16'd300;
    localparam logic [HOLD_W-1:0]  HOLD_MAX           = '1;
    localparam logic [LEAF_W-1:0]  LEAF_BOOST         = 16'd200;
    localparam logic signed [MOIST_W:0] MOIST_DROP    = 17'sd350;
    localparam logic signed [MOIST_W:0] MOIST_MAX     = 17'sd1000;
    localparam logic [ILLUM_W-1:0] ILLUM_MAX          = '1;

    typedef struct packed {
        logic             active;
        logic [SCN_W-1:0] scenario;
    } bms_mode_t;

    typedef struct packed {
        logic                      pressed;
        logic signed [LEAF_W-1:0]  leaf_temp;
        logic signed [MOIST_W-1:0] soil_moisture;
        logic [ILLUM_W-1:0]        illuminance;
        logic                      tank_liquid;
        logic [FAULT_W-1:0]        soil_health;
    } bms_sample_t;

endpackage

/* sv/bms_switch.sv */
// ----------------------------------------------------------------------------
// bms_switch
// Hold counter and press classifier; owns the override mode and scenario.
// ----------------------------------------------------------------------------
module bms_switch (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       tick_en,
    input  logic                       pressed,
    input  logic [bms_pkg::HOLD_W-1:0] hold_threshold,
    output bms_pkg::bms_mode_t         mode_now,
    output bms_pkg::bms_mode_t         mode_next
);
    import bms_pkg::*;

    logic [HOLD_W-1:0] hold_count_reg, hold_count_next;
    logic              long_done_reg, long_done_next;
    bms_mode_t         mode_reg;
    logic [HOLD_W-1:0] hold_inc;

    assign hold_inc = (hold_count_reg == HOLD_MAX) ? hold_count_reg : hold_count_reg + 1'b1;

    always_comb begin
        hold_count_next = hold_count_reg;
        long_done_next  = long_done_reg;
        mode_next       = mode_reg;
        if (tick_en) begin
            if (pressed) begin
                hold_count_next = hold_inc;
                // toggle once per press
                if (hold_inc >= hold_threshold && !long_done_reg) begin
                    long_done_next = 1'b1;
                    if (mode_reg.active) begin
                        mode_next.active   = 1'b0;
                        mode_next.scenario = SCN_OFF;
                    end else begin
                        mode_next.active   = 1'b1;
                        mode_next.scenario = SCN_CLAMP;
                    end
                end
            end else begin
                // short press seen on release: advance and wrap
                if (!long_done_reg && hold_count_reg != '0 && mode_reg.active) begin
                    if (mode_reg.scenario >= SCN_LAST) begin
                        mode_next.scenario = SCN_CLAMP;
                    end else begin
                        mode_next.scenario = mode_reg.scenario + 1'b1;
                    end
                end
                hold_count_next = '0;
                long_done_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_count_reg <= '0;
            long_done_reg  <= 1'b0;
            mode_reg       <= '{active: 1'b0, scenario: SCN_OFF};
        end else begin
            hold_count_reg <= hold_count_next;
            long_done_reg  <= long_done_next;
            mode_reg       <= mode_next;
        end
    end

    assign mode_now = mode_reg;

endmodule

/* sv/bms_override.sv */
// ----------------------------------------------------------------------------
// bms_override
// Rewrites one sensor sample according to the current scenario.
// ----------------------------------------------------------------------------
module bms_override (
    input  logic                        is_sample,
    input  bms_pkg::bms_mode_t          mode,
    input  logic [bms_pkg::FAULT_W-1:0] fault_code,
    input  bms_pkg::bms_sample_t        sample_in,
    output bms_pkg::bms_sample_t        sample_out
);
    import bms_pkg::*;

    logic signed [MOIST_W:0] moist_wide;
    logic signed [MOIST_W:0] moist_drop;
    logic [ILLUM_W-1:0]      illum_dbl;

    assign moist_wide = {sample_in.soil_moisture[MOIST_W-1], sample_in.soil_moisture};
    assign moist_drop = (mode.scenario == SCN_DRY || mode.scenario == SCN_EMPTY)
                        ? moist_wide - MOIST_DROP : moist_wide;
    assign illum_dbl  = sample_in.illuminance[ILLUM_W-1] ? ILLUM_MAX
                        : {sample_in.illuminance[ILLUM_W-2:0], 1'b0};

    always_comb begin
        sample_out         = sample_in;
        sample_out.pressed = 1'b0;
        if (!is_sample) begin
            sample_out = '0;
        end else if (mode.active) begin
            if (mode.scenario == SCN_BOOST) begin
                sample_out.leaf_temp   = sample_in.leaf_temp + $signed(LEAF_BOOST);
                sample_out.illuminance = illum_dbl;
            end
            // clamp moisture to 0..1000
            if (moist_drop < 0) begin
                sample_out.soil_moisture = '0;
            end else if (moist_drop > MOIST_MAX) begin
                sample_out.soil_moisture = MOIST_MAX[MOIST_W-1:0];
            end else begin
                sample_out.soil_moisture = moist_drop[MOIST_W-1:0];
            end
            if (mode.scenario == SCN_EMPTY) begin
                sample_out.tank_liquid = 1'b0;
            end
            if (mode.scenario == SCN_FAULT) begin
                sample_out.soil_health = fault_code;
            end
        end
    end

endmodule

/* sv/button_mode_sequencer_sensor_override.sv */
// ----------------------------------------------------------------------------
// button_mode_sequencer_sensor_override
// Switch tick press classifier with scenario-driven sensor sample override.
// ----------------------------------------------------------------------------
// Path: an accepted word goes through the input register, then the result register
// (the press logic and override sit between them); a stalled result holds it back.
// Throughput: one word per cycle while m_axis_tready stays high; the input register
// can take one new word while the previous result waits.
// Reset: synchronous, active low; clears the mode, scenario, hold counter,
// valid flags, and restores hold_threshold to 300 and the fault code to 0.
module button_mode_sequencer_sensor_override (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // switch_pressed[0], leaf_temp_in[16:1], soil_moisture_in[32:17],
    // illuminance_in[63:33], tank_liquid_in[64], soil_health_in[67:65], zero fill
    input  logic [bms_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // mode[0]
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // override_active[0], scenario_now[3:1], leaf_temp_out[19:4],
    // soil_moisture_out[35:20], illuminance_out[66:36], tank_liquid_out[67],
    // soil_health_out[70:68], zero fill
    output logic [bms_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bms_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bms_pkg::*;

    logic [HOLD_W-1:0]  hold_threshold_reg;
    logic [FAULT_W-1:0] fault_code_reg;

    logic        in_valid_reg;
    logic        in_mode_reg;
    bms_sample_t in_sample_reg;
    logic        out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic        advance;
    bms_mode_t   mode_now, mode_next;
    bms_sample_t sample_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_threshold_reg <= HOLD_THRESHOLD_RST;
            fault_code_reg     <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_HOLD_THRESHOLD: hold_threshold_reg <= cfg_data[HOLD_W-1:0];
                CFG_FAULT_CODE:     fault_code_reg     <= cfg_data[FAULT_W-1:0];
                default: ;
            endcase
        end
    end

    // move the held word on when the result register is free or being drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_mode_reg   <= s_axis_tuser;
            in_sample_reg <= '{pressed:       s_axis_tdata[0],
                               leaf_temp:     s_axis_tdata[16:1],
                               soil_moisture: s_axis_tdata[32:17],
                               illuminance:   s_axis_tdata[63:33],
                               tank_liquid:   s_axis_tdata[64],
                               soil_health:   s_axis_tdata[67:65]};
        end
    end

    bms_switch u_switch (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .tick_en        (advance && !in_mode_reg),
        .pressed        (in_sample_reg.pressed),
        .hold_threshold (hold_threshold_reg),
        .mode_now       (mode_now),
        .mode_next      (mode_next)
    );

    bms_override u_override (
        .is_sample  (in_mode_reg),
        .mode       (mode_now),
        .fault_code (fault_code_reg),
        .sample_in  (in_sample_reg),
        .sample_out (sample_out)
    );

    assign out_data_next = {1'b0,
                            sample_out.soil_health,
                            sample_out.tank_liquid,
                            sample_out.illuminance,
                            sample_out.soil_moisture,
                            sample_out.leaf_temp,
                            mode_next.scenario,
                            mode_next.active};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

/* sv/bms_checker.sv */
// ----------------------------------------------------------------------------
// bms_checker
// Port-level checks on the result stream of the mode sequencer.
// ----------------------------------------------------------------------------
module bms_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [bms_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import bms_pkg::*;

    // hold a stalled result word
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid straight after reset");

    a_off_scenario: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[3:1] == SCN_OFF)
        else $error("scenario set while override inactive");

    a_on_scenario: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[0] |->
        m_axis_tdata[3:1] != SCN_OFF && m_axis_tdata[3:1] <= SCN_LAST)
        else $error("scenario out of range while override active");

    a_fill_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !m_axis_tdata[OUT_DATA_W-1])
        else $error("fill bit set in result word");

endmodule

bind button_mode_sequencer_sensor_override bms_checker u_bms_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
